@@ rtl/tsdf_voxel_fusion_update_macros.svh @@
// assertion macros for the fusion update rtl
`ifndef TSDF_VOXEL_FUSION_UPDATE_MACROS_SVH
`define TSDF_VOXEL_FUSION_UPDATE_MACROS_SVH

// same-cycle implication under reset
`define TVFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define TVFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tvfu_pkg.sv @@
// types and constants of the tsdf voxel fusion update
package tvfu_pkg;

	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic signed [23:0] LEN_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] LEN_MIN = 24'sh800000;
	localparam logic [15:0] CONF_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		CFG_TRUNC_DIST   = 3'd0,
		CFG_MAX_WEIGHT   = 3'd1,
		CFG_DROPOFF_EN   = 3'd2,
		CFG_SPARSITY_EN  = 3'd3,
		CFG_SPARSITY_FAC = 3'd4,
		CFG_VOXEL_SIZE   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [23:0] ray_x;
		logic signed [23:0] ray_y;
		logic signed [23:0] ray_z;
		logic signed [23:0] centre_x;
		logic signed [23:0] centre_y;
		logic signed [23:0] centre_z;
		logic [31:0]        meas_weight;
		logic [15:0]        meas_object;
		logic signed [23:0] cur_distance;
		logic [31:0]        cur_weight;
		logic [15:0]        cur_object;
		logic [15:0]        cur_confidence;
	} upd_t;

	typedef struct packed {
		logic signed [23:0] new_distance;
		logic [31:0]        fused_wt;
		logic [15:0]        new_object;
		logic [15:0]        new_confidence;
		logic               fused;
		logic               near_surface;
	} res_t;

	typedef struct packed {
		logic [22:0] trunc_dist;
		logic [31:0] weight_cap;
		logic        weight_dropoff_enable;
		logic        sparsity_enable;
		logic [15:0] sparsity_factor;
		logic [22:0] vox_edge;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		trunc_dist:            23'd65536,
		weight_cap:            32'd655360000,
		weight_dropoff_enable: 1'b1,
		sparsity_enable:       1'b0,
		sparsity_factor:       16'd256,
		vox_edge:              23'd6554
	};

	typedef struct packed {
		logic [31:0]        meas_weight;
		logic signed [23:0] cur_distance;
		logic [31:0]        cur_weight;
		logic [15:0]        obj;
		logic [15:0]        conf;
	} ctx_t;

	typedef struct packed {
		logic [47:0]        sumsq;
		logic signed [48:0] dot;
		ctx_t               ctx;
	} qitem_t;

	typedef struct packed {
		logic signed [49:0] num;
		ctx_t               ctx;
	} sq_side_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic lz;
		ctx_t ctx;
	} d1_side_t;

	typedef struct packed {
		logic signed [23:0] sdf;
		logic               near;
		ctx_t               ctx;
	} wt_t;

	typedef struct packed {
		logic        use_div;
		logic        zero_w;
		logic [22:0] numd;
		logic [22:0] den;
		wt_t         wt;
	} dw_t;

	typedef struct packed {
		logic use_div;
		logic zero_w;
		wt_t  wt;
	} d2_side_t;

	typedef struct packed {
		logic               neg;
		logic [32:0]        new_w;
		logic signed [23:0] cur_distance;
		logic [31:0]        cur_weight;
		logic [15:0]        obj;
		logic [15:0]        conf;
		logic               near;
	} fz_t;

endpackage

@@ rtl/tvfu_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module tvfu_sqrt import tvfu_pkg::*; #(
	parameter int IN_W   = 48,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [IN_W/2-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RES_W = IN_W / 2;

	logic [RES_W+1:0]  rem_q  [RES_W];
	logic [RES_W-1:0]  root_q [RES_W];
	logic [IN_W-1:0]   x_q    [RES_W];
	logic [SIDE_W-1:0] side_q [RES_W];
	logic              v_q    [RES_W];

	for (genvar i = 0; i < RES_W; i++) begin : g_step
		logic [RES_W+1:0]  rem_in;
		logic [RES_W-1:0]  root_in;
		logic [IN_W-1:0]   x_in;
		logic [SIDE_W-1:0] side_prev;
		logic              v_prev;
		logic [RES_W+3:0]  t;
		logic [RES_W+3:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_in    = '0;
			assign root_in   = '0;
			assign x_in      = radicand;
			assign side_prev = side_in;
			assign v_prev    = in_valid;
		end else begin : g_next
			assign rem_in    = rem_q[i-1];
			assign root_in   = root_q[i-1];
			assign x_in      = x_q[i-1];
			assign side_prev = side_q[i-1];
			assign v_prev    = v_q[i-1];
		end

		assign t     = {rem_in, x_in[IN_W-1 -: 2]};
		assign trial = (RES_W+4)'({root_in, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? (RES_W+2)'(t - trial) : (RES_W+2)'(t);
				root_q[i] <= {root_in[RES_W-2:0], ge};
				x_q[i]    <= {x_in[IN_W-3:0], 2'b00};
				side_q[i] <= side_prev;
			end
		end
	end

	assign out_valid = v_q[RES_W-1];
	assign root      = root_q[RES_W-1];
	assign side_out  = side_q[RES_W-1];

endmodule

@@ rtl/tvfu_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module tvfu_div import tvfu_pkg::*; #(
	parameter int DIVISOR_W = 24,
	parameter int QUO_W     = 24,
	parameter int SIDE_W    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [DIVISOR_W+QUO_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]       divisor,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_valid,
	output logic [QUO_W-1:0]           quotient,
	output logic [SIDE_W-1:0]          side_out
);

	logic [DIVISOR_W-1:0] rem_q  [QUO_W];
	logic [QUO_W-1:0]     low_q  [QUO_W];
	logic [DIVISOR_W-1:0] d_q    [QUO_W];
	logic [SIDE_W-1:0]    side_q [QUO_W];
	logic                 v_q    [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [DIVISOR_W-1:0] rem_in;
		logic [QUO_W-1:0]     low_in;
		logic [DIVISOR_W-1:0] d_in;
		logic [SIDE_W-1:0]    side_prev;
		logic                 v_prev;
		logic [DIVISOR_W:0]   t;
		logic                 ge;

		if (i == 0) begin : g_first
			assign rem_in    = dividend[DIVISOR_W+QUO_W-1:QUO_W];
			assign low_in    = dividend[QUO_W-1:0];
			assign d_in      = divisor;
			assign side_prev = side_in;
			assign v_prev    = in_valid;
		end else begin : g_next
			assign rem_in    = rem_q[i-1];
			assign low_in    = low_q[i-1];
			assign d_in      = d_q[i-1];
			assign side_prev = side_q[i-1];
			assign v_prev    = v_q[i-1];
		end

		assign t  = {rem_in, low_in[QUO_W-1]};
		assign ge = t >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? DIVISOR_W'(t - {1'b0, d_in}) : DIVISOR_W'(t);
				low_q[i]  <= {low_in[QUO_W-2:0], ge};
				d_q[i]    <= d_in;
				side_q[i] <= side_prev;
			end
		end
	end

	assign out_valid = v_q[QUO_W-1];
	assign quotient  = low_q[QUO_W-1];
	assign side_out  = side_q[QUO_W-1];

endmodule

@@ rtl/tvfu_front.sv @@
// front end: takes update beats, forms ray products and the object vote
module tvfu_front import tvfu_pkg::*; #(
	parameter int OBJECT_ID_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd_valid,
	output logic              upd_stall,
	input  upd_t              upd_data,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output qitem_t            push_data
);

	localparam logic [15:0] ID_MASK = (OBJECT_ID_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << OBJECT_ID_BITS) - 32'd1);

	logic               v_s1;
	upd_t               u_s1;
	logic signed [47:0] sqx, sqy, sqz, dpx, dpy, dpz;
	logic [15:0]        mobj, cobj, obj_v, conf_v;
	logic [QCNT_W:0]    inflight;
	logic               accept;

	logic               v_s2;
	logic [46:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [47:0] dpx_s2, dpy_s2, dpz_s2;
	ctx_t               ctx_s2;

	assign inflight = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2);
	assign upd_stall = inflight >= (QCNT_W+1)'(QDEPTH);
	assign accept = upd_valid && !upd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_s1 <= upd_data;
		end
	end

	assign sqx = u_s1.ray_x * u_s1.ray_x;
	assign sqy = u_s1.ray_y * u_s1.ray_y;
	assign sqz = u_s1.ray_z * u_s1.ray_z;
	assign dpx = u_s1.centre_x * u_s1.ray_x;
	assign dpy = u_s1.centre_y * u_s1.ray_y;
	assign dpz = u_s1.centre_z * u_s1.ray_z;

	assign mobj = u_s1.meas_object & ID_MASK;
	assign cobj = u_s1.cur_object & ID_MASK;

	// confidence vote on the object id
	always_comb begin
		obj_v  = cobj;
		conf_v = u_s1.cur_confidence;
		if (u_s1.cur_confidence == '0) begin
			obj_v  = mobj;
			conf_v = 16'd1;
		end else if (cobj == mobj) begin
			if (u_s1.cur_confidence != CONF_MAX) begin
				conf_v = u_s1.cur_confidence + 16'd1;
			end
		end else begin
			conf_v = u_s1.cur_confidence - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2              <= sqx[46:0];
		sqy_s2              <= sqy[46:0];
		sqz_s2              <= sqz[46:0];
		dpx_s2              <= dpx;
		dpy_s2              <= dpy;
		dpz_s2              <= dpz;
		ctx_s2.meas_weight  <= u_s1.meas_weight;
		ctx_s2.cur_distance <= u_s1.cur_distance;
		ctx_s2.cur_weight   <= u_s1.cur_weight;
		ctx_s2.obj          <= obj_v;
		ctx_s2.conf         <= conf_v;
	end

	assign push = v_s2;
	assign push_data.sumsq = 48'(sqx_s2) + 48'(sqy_s2) + 48'(sqz_s2);
	assign push_data.dot = 49'(dpx_s2) + 49'(dpy_s2) + 49'(dpz_s2);
	assign push_data.ctx = ctx_s2;

endmodule

@@ rtl/tvfu_queue.sv @@
// short queue between front and back ends
`include "tsdf_voxel_fusion_update_macros.svh"

module tvfu_queue import tvfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qitem_t            push_data,
	input  logic              pop,
	output qitem_t            pop_data,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	qitem_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_q];
	assign empty    = count_q == '0;
	assign count    = count_q;

	`TVFU_ASSERT_NOW(a_no_overflow, clk, arst_n, push, (count_q != QCNT_W'(QDEPTH)) || pop, "queue push while full")
	`TVFU_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, count_q != '0, "queue pop while empty")
	`TVFU_ASSERT_NOW(a_empty_ptrs, clk, arst_n, count_q == '0, wr_q == rd_q, "queue pointers apart while empty")

endmodule

@@ rtl/tvfu_back.sv @@
// back end: sqrt, divides and weighted fusion, ending in the result register
module tvfu_back import tvfu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   q_empty,
	output logic   q_pop,
	input  qitem_t q_data,
	output logic   res_valid,
	input  logic   res_stall,
	output res_t   res_data
);

	logic adv;
	logic res_valid_q;
	res_t res_q;

	logic               v_b0, v_b1, v_b2, v_b3, v_b4, v_b5, v_b6, v_b7, v_b8, v_b9, v_b10;
	logic               v_sq, v_d1, v_d2, v_d3;

	qitem_t             it_b0;
	logic signed [49:0] num_b0;
	sq_side_t           sq_in, sq_out;
	logic [$bits(sq_side_t)-1:0] sq_out_vec;
	logic [23:0]        len_sq;

	logic [49:0]        mag_b1;
	logic               neg_b1;
	logic [23:0]        len_b1;
	ctx_t               ctx_b1;
	logic               lz_b1, ovf_b1;
	d1_side_t           d1_in, d1_out;
	logic [$bits(d1_side_t)-1:0] d1_out_vec;
	logic [23:0]        q1;
	logic signed [23:0] sdf_d1;

	logic signed [23:0] sdf_b2;
	ctx_t               ctx_b2;
	logic signed [24:0] sdf25, abs25, tpos, vpos, numd, den;
	dw_t                dw_d2;

	dw_t                dw_b3, dw_b4;
	logic [54:0]        prod_b3, prod_b4;
	d2_side_t           d2_in, d2_out;
	logic [$bits(d2_side_t)-1:0] d2_out_vec;
	logic [31:0]        q2;
	wt_t                wt_d5;

	wt_t                wt_b5, wt_b6, wt_d7, wt_b7;
	logic [47:0]        spar_b5, spar_b6;
	logic               take_b6;

	logic signed [56:0] p1_b7, p2_b7, p1_b8, p2_b8;
	fz_t                fz_d8, fz_b8, fz_b9, fz_d10, fz_b10;
	logic signed [57:0] acc_b8, acc_b9;
	logic [56:0]        mag_b9, mag_b10;
	logic [$bits(fz_t)-1:0] d3_out_vec;
	fz_t                fz_o;
	logic [23:0]        q3;
	logic signed [24:0] nd, nd_c;
	logic               fused;
	res_t               res_d;

	assign adv   = !res_valid_q || !res_stall;
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b0        <= 1'b0;
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			v_b3        <= 1'b0;
			v_b4        <= 1'b0;
			v_b5        <= 1'b0;
			v_b6        <= 1'b0;
			v_b7        <= 1'b0;
			v_b8        <= 1'b0;
			v_b9        <= 1'b0;
			v_b10       <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_b0        <= !q_empty;
			v_b1        <= v_sq;
			v_b2        <= v_d1;
			v_b3        <= v_b2;
			v_b4        <= v_b3;
			v_b5        <= v_d2;
			v_b6        <= v_b5;
			v_b7        <= v_b6;
			v_b8        <= v_b7;
			v_b9        <= v_b8;
			v_b10       <= v_b9;
			res_valid_q <= v_d3;
		end
	end

	// ray length
	assign num_b0     = $signed({2'b00, it_b0.sumsq}) - 50'(it_b0.dot);
	assign sq_in.num  = num_b0;
	assign sq_in.ctx  = it_b0.ctx;

	tvfu_sqrt #(
		.IN_W   (48),
		.SIDE_W ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_b0),
		.radicand  (it_b0.sumsq),
		.side_in   (sq_in),
		.out_valid (v_sq),
		.root      (len_sq),
		.side_out  (sq_out_vec)
	);
	assign sq_out = sq_side_t'(sq_out_vec);

	// signed distance divide
	assign lz_b1      = len_b1 == '0;
	assign ovf_b1     = mag_b1[49:24] >= {2'b00, len_b1};
	assign d1_in.neg  = neg_b1;
	assign d1_in.ovf  = ovf_b1;
	assign d1_in.lz   = lz_b1;
	assign d1_in.ctx  = ctx_b1;

	tvfu_div #(
		.DIVISOR_W (24),
		.QUO_W     (24),
		.SIDE_W    ($bits(d1_side_t))
	) u_div_sdf (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_b1),
		.dividend  ((lz_b1 || ovf_b1) ? 48'd0 : mag_b1[47:0]),
		.divisor   (lz_b1 ? 24'd1 : len_b1),
		.side_in   (d1_in),
		.out_valid (v_d1),
		.quotient  (q1),
		.side_out  (d1_out_vec)
	);
	assign d1_out = d1_side_t'(d1_out_vec);

	always_comb begin
		if (d1_out.lz) begin
			sdf_d1 = '0;
		end else if (d1_out.ovf) begin
			sdf_d1 = d1_out.neg ? LEN_MIN : LEN_MAX;
		end else if (d1_out.neg) begin
			sdf_d1 = (q1 > 24'd8388608) ? LEN_MIN : $signed(-q1);
		end else begin
			sdf_d1 = q1[23] ? LEN_MAX : $signed(q1);
		end
	end

	// dropoff classification
	assign sdf25 = 25'(sdf_b2);
	assign abs25 = sdf25[24] ? -sdf25 : sdf25;
	assign tpos  = $signed({2'b00, cfg.trunc_dist});
	assign vpos  = $signed({2'b00, cfg.vox_edge});
	assign numd  = tpos + sdf25;
	assign den   = tpos - vpos;

	always_comb begin
		logic drop, dz;
		drop = cfg.weight_dropoff_enable && (sdf25 < -vpos);
		dz   = (numd <= 25'sd0) || (den <= 25'sd0);
		dw_d2.use_div = drop && !dz;
		dw_d2.zero_w  = drop && dz;
		dw_d2.numd    = numd[22:0];
		dw_d2.den     = den[22:0];
		dw_d2.wt.sdf  = sdf_b2;
		dw_d2.wt.near = abs25 < tpos;
		dw_d2.wt.ctx  = ctx_b2;
	end

	assign prod_b3 = 55'(dw_b3.wt.ctx.meas_weight) * 55'(dw_b3.numd);

	assign d2_in.use_div = dw_b4.use_div;
	assign d2_in.zero_w  = dw_b4.zero_w;
	assign d2_in.wt      = dw_b4.wt;

	tvfu_div #(
		.DIVISOR_W (23),
		.QUO_W     (32),
		.SIDE_W    ($bits(d2_side_t))
	) u_div_drop (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_b4),
		.dividend  (dw_b4.use_div ? prod_b4 : 55'd0),
		.divisor   (dw_b4.use_div ? dw_b4.den : 23'd1),
		.side_in   (d2_in),
		.out_valid (v_d2),
		.quotient  (q2),
		.side_out  (d2_out_vec)
	);
	assign d2_out = d2_side_t'(d2_out_vec);

	always_comb begin
		wt_d5 = d2_out.wt;
		if (d2_out.use_div) begin
			wt_d5.ctx.meas_weight = q2;
		end else if (d2_out.zero_w) begin
			wt_d5.ctx.meas_weight = '0;
		end
	end

	// near-surface scaling
	assign spar_b5 = 48'(wt_b5.ctx.meas_weight) * 48'(cfg.sparsity_factor);

	always_comb begin
		wt_d7 = wt_b6;
		if (take_b6) begin
			wt_d7.ctx.meas_weight = (|spar_b6[47:40]) ? 32'hFFFFFFFF : spar_b6[39:8];
		end
	end

	// weighted average
	assign p1_b7 = 57'(wt_b7.sdf) * $signed({25'd0, wt_b7.ctx.meas_weight});
	assign p2_b7 = 57'(wt_b7.ctx.cur_distance) * $signed({25'd0, wt_b7.ctx.cur_weight});

	assign fz_d8.neg          = 1'b0;
	assign fz_d8.new_w        = {1'b0, wt_b7.ctx.cur_weight} + {1'b0, wt_b7.ctx.meas_weight};
	assign fz_d8.cur_distance = wt_b7.ctx.cur_distance;
	assign fz_d8.cur_weight   = wt_b7.ctx.cur_weight;
	assign fz_d8.obj          = wt_b7.ctx.obj;
	assign fz_d8.conf         = wt_b7.ctx.conf;
	assign fz_d8.near         = wt_b7.near;

	assign acc_b8 = 58'(p1_b8) + 58'(p2_b8);
	assign mag_b9 = acc_b9[57] ? 57'(-acc_b9) : 57'(acc_b9);

	always_comb begin
		fz_d10     = fz_b9;
		fz_d10.neg = acc_b9[57];
	end

	tvfu_div #(
		.DIVISOR_W (33),
		.QUO_W     (24),
		.SIDE_W    ($bits(fz_t))
	) u_div_fuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_b10),
		.dividend  (mag_b10),
		.divisor   ((fz_b10.new_w == '0) ? 33'd1 : fz_b10.new_w),
		.side_in   (fz_b10),
		.out_valid (v_d3),
		.quotient  (q3),
		.side_out  (d3_out_vec)
	);
	assign fz_o = fz_t'(d3_out_vec);

	assign nd    = fz_o.neg ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
	assign fused = fz_o.new_w != '0;

	always_comb begin
		nd_c = nd;
		if (nd > tpos) begin
			nd_c = tpos;
		end else if (nd < -tpos) begin
			nd_c = -tpos;
		end
	end

	always_comb begin
		res_d.new_distance   = fused ? nd_c[23:0] : fz_o.cur_distance;
		res_d.fused_wt       = fz_o.cur_weight;
		if (fused) begin
			res_d.fused_wt = (fz_o.new_w < {1'b0, cfg.weight_cap}) ?
				fz_o.new_w[31:0] : cfg.weight_cap;
		end
		res_d.new_object     = fz_o.obj;
		res_d.new_confidence = fz_o.conf;
		res_d.fused          = fused;
		res_d.near_surface   = fused && fz_o.near;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_b0   <= q_data;
			mag_b1  <= sq_out.num[49] ? 50'(-sq_out.num) : 50'(sq_out.num);
			neg_b1  <= sq_out.num[49];
			len_b1  <= len_sq;
			ctx_b1  <= sq_out.ctx;
			sdf_b2  <= sdf_d1;
			ctx_b2  <= d1_out.ctx;
			dw_b3   <= dw_d2;
			dw_b4   <= dw_b3;
			prod_b4 <= prod_b3;
			wt_b5   <= wt_d5;
			spar_b6 <= spar_b5;
			take_b6 <= cfg.sparsity_enable && wt_b5.near;
			wt_b6   <= wt_b5;
			wt_b7   <= wt_d7;
			p1_b8   <= p1_b7;
			p2_b8   <= p2_b7;
			fz_b8   <= fz_d8;
			acc_b9  <= acc_b8;
			fz_b9   <= fz_b8;
			mag_b10 <= mag_b9;
			fz_b10  <= fz_d10;
			res_q   <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ rtl/tsdf_voxel_fusion_update.sv @@
// top level of the tsdf voxel fusion update
//
//  channel  handshake            beat
//  upd      upd_valid/upd_stall  upd_data: one voxel update
//  res      res_valid/res_stall  res_data: fused voxel
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one update taken per cycle while upd_stall is low; updates pass to results through
// the square root and the three one-bit-per-stage dividers in the back end
// back end advances as one while the result register is free
// a result stall fills the four-entry queue, then stalls updates
// asynchronous reset clears control and loads register defaults; no clearing pass
module tsdf_voxel_fusion_update import tvfu_pkg::*; #(
	parameter int OBJECT_ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd_valid,
	output logic        upd_stall,
	input  upd_t        upd_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t              cfg_q;
	logic              push, pop, empty;
	qitem_t            push_data, pop_data;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TRUNC_DIST:   cfg_q.trunc_dist            <= cfg_data[22:0];
				CFG_MAX_WEIGHT:   cfg_q.weight_cap            <= cfg_data;
				CFG_DROPOFF_EN:   cfg_q.weight_dropoff_enable <= cfg_data[0];
				CFG_SPARSITY_EN:  cfg_q.sparsity_enable       <= cfg_data[0];
				CFG_SPARSITY_FAC: cfg_q.sparsity_factor       <= cfg_data[15:0];
				CFG_VOXEL_SIZE:   cfg_q.vox_edge              <= cfg_data[22:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	tvfu_front #(
		.OBJECT_ID_BITS (OBJECT_ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_valid (upd_valid),
		.upd_stall (upd_stall),
		.upd_data  (upd_data),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	tvfu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty),
		.count     (q_count)
	);

	tvfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (empty),
		.q_pop     (pop),
		.q_data    (pop_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
